>>> rtl/sha1mh_pkg.sv
`timescale 1ns / 1ps
package sha1mh_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        digest_last;
	} out_item_t;

	// head of the input queue as seen by the core
	typedef struct packed {
		logic     valid;
		in_item_t item;
	} q_head_t;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K_G0 = 32'h5A827999;
	localparam logic [31:0] K_G1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_G2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_G3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

>>> rtl/sha1_message_hasher.sv
`timescale 1ns / 1ps
// SHA-1 over a byte stream. Each item transfer carries at most one message byte and may end
// the message; after the end item the block returns the digest as five 32-bit word
// transfers, h0 first, digest_last set on h4, and starts a fresh message. Input items
// land in a small queue (QueueDepth entries) in front of the hashing core, so the
// input side keeps taking items while the core compresses or while a digest waits to
// be taken, until the queue is full. The core handles one item at a time, and the byte
// that completes a 64-byte block adds one compression (80 rounds, chain update; the
// load shares the byte's own cycle) on the single round unit.
// An end item adds a pad step plus one compression, or two compressions and a length
// step when fewer than 9 bytes remain in the block, then hands the digest to the output
// register; a second digest waits in the core until the previous one has fully drained.
module sha1_message_hasher
	import sha1mh_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      digest_valid,
	input  logic      digest_stall,
	output out_item_t digest
);

	q_head_t head;
	logic    pop;

	sha1mh_queue #(.Depth(QueueDepth)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.head       (head),
		.pop        (pop)
	);

	sha1mh_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest)
	);

endmodule

>>> rtl/sha1mh_queue.sv
`timescale 1ns / 1ps
module sha1mh_queue
	import sha1mh_pkg::*;
#(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  in_item_t item,
	output q_head_t  head,
	input  logic     pop
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	in_item_t            mem_q [Depth];
	logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]     count_q;
	logic                push, do_pop;

	assign item_stall = (count_q == CntW'(Depth));
	assign push       = item_valid && !item_stall;
	assign do_pop     = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= item;
	end

endmodule

>>> rtl/sha1mh_core.sv
`timescale 1ns / 1ps
module sha1mh_core
	import sha1mh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  q_head_t   head,
	output logic      pop,
	output logic      digest_valid,
	input  logic      digest_stall,
	output out_item_t digest
);

	typedef enum logic [2:0] {
		S_IDLE, S_COMP, S_FIN, S_PAD, S_LEN, S_OUT
	} state_t;

	state_t       state_q, after_q;
	logic [6:0]   round_q;
	logic [63:0]  count_q;
	logic [31:0]  chain_q [5];
	logic         out_busy_q;
	logic [2:0]   out_idx_q;

	logic [31:0]  w_q [16];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [31:0]  dig_q [5];

	logic [5:0]   pos;
	logic         byte_wr, pad_wr, len_wr, comp_start, round_en, dig_load, out_xfer;
	logic [31:0]  w_new, w_cur, f, k, t;
	logic [31:0]  pad_word [16];

	assign pos      = count_q[8:3];
	assign pop      = (state_q == S_IDLE) && head.valid;
	assign byte_wr  = pop && head.item.byte_present;
	assign pad_wr   = (state_q == S_PAD);
	assign len_wr   = (state_q == S_LEN);
	assign round_en = (state_q == S_COMP);
	assign dig_load = (state_q == S_OUT) && !out_busy_q;
	assign out_xfer = digest_valid && !digest_stall;

	always_comb begin
		comp_start = 1'b0;
		if (pad_wr || len_wr) comp_start = 1'b1;
		if (byte_wr && pos == 6'd63) comp_start = 1'b1;
	end

	// rolling schedule: w_cur is the word for this round, w_q[0] in the first 16 rounds
	assign w_new = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
	                w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};
	assign w_cur = (round_q < 7'd16) ? w_q[0] : w_new;

	always_comb begin
		priority if (round_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K_G0;
		end else if (round_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K_G1;
		end else if (round_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K_G2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K_G3;
		end
	end

	assign t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_cur;

	// 0x80 at the current position, zeros after, earlier bytes kept
	always_comb begin
		for (int wi = 0; wi < 16; wi++) begin
			for (int bj = 0; bj < 4; bj++) begin
				if (6'(wi * 4 + bj) < pos)
					pad_word[wi][31-8*bj -: 8] = w_q[wi][31-8*bj -: 8];
				else if (6'(wi * 4 + bj) == pos)
					pad_word[wi][31-8*bj -: 8] = PAD_BYTE;
				else
					pad_word[wi][31-8*bj -: 8] = 8'h00;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			after_q    <= S_IDLE;
			round_q    <= '0;
			count_q    <= '0;
			out_busy_q <= 1'b0;
			out_idx_q  <= '0;
			for (int i = 0; i < 5; i++) chain_q[i] <= H_INIT[i];
		end else begin
			if (out_xfer) begin
				if (out_idx_q == 3'd4) begin
					out_busy_q <= 1'b0;
					out_idx_q  <= '0;
				end else begin
					out_idx_q <= out_idx_q + 1'b1;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (head.item.byte_present) count_q <= count_q + 64'd8;
						if (head.item.byte_present && pos == 6'd63) begin
							state_q <= S_COMP;
							after_q <= head.item.end_of_message ? S_PAD : S_IDLE;
							round_q <= '0;
						end else if (head.item.end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_COMP: begin
					round_q <= round_q + 1'b1;
					if (round_q == 7'd79) state_q <= S_FIN;
				end
				S_FIN: begin
					for (int i = 0; i < 5; i++) chain_q[i] <= chain_q[i] + (
						(i == 0) ? a_q : (i == 1) ? b_q : (i == 2) ? c_q :
						(i == 3) ? d_q : e_q);
					state_q <= after_q;
				end
				S_PAD: begin
					state_q <= S_COMP;
					round_q <= '0;
					after_q <= (pos >= 6'd56) ? S_LEN : S_OUT;
				end
				S_LEN: begin
					state_q <= S_COMP;
					round_q <= '0;
					after_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_busy_q) begin
						out_busy_q <= 1'b1;
						out_idx_q  <= '0;
						count_q    <= '0;
						for (int i = 0; i < 5; i++) chain_q[i] <= H_INIT[i];
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (byte_wr)
			w_q[pos[5:2]][31 - 8*pos[1:0] -: 8] <= head.item.data_byte;
		if (pad_wr) begin
			for (int i = 0; i < 14; i++) w_q[i] <= pad_word[i];
			if (pos < 6'd56) begin
				w_q[14] <= count_q[63:32];
				w_q[15] <= count_q[31:0];
			end else begin
				w_q[14] <= pad_word[14];
				w_q[15] <= pad_word[15];
			end
		end
		if (len_wr) begin
			for (int i = 0; i < 14; i++) w_q[i] <= '0;
			w_q[14] <= count_q[63:32];
			w_q[15] <= count_q[31:0];
		end
		if (round_en) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_cur;
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (comp_start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end
		if (dig_load)
			for (int i = 0; i < 5; i++) dig_q[i] <= chain_q[i];
	end

	assign digest_valid       = out_busy_q;
	assign digest.digest_word = dig_q[out_idx_q];
	assign digest.digest_last = (out_idx_q == 3'd4);

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMP) |-> (round_q <= 7'd79))
		else $error("round index out of range");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		dig_load |-> !out_busy_q)
		else $error("digest reloaded while draining");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && out_idx_q == 3'd4) |=> !out_busy_q)
		else $error("digest output still busy after last word");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_busy_q |-> (out_idx_q <= 3'd4))
		else $error("digest word index out of range");

endmodule

>>> dv/tb_sha1_message_hasher.sv
`timescale 1ns / 1ps
module tb_sha1_message_hasher;
	import sha1mh_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	in_item_t  item;
	logic      digest_valid;
	logic      digest_stall;
	out_item_t digest;

	sha1_message_hasher u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.digest_valid(digest_valid),
		.digest_stall(digest_stall),
		.digest      (digest)
	);

	// 4 ns period
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// ---------------------------------------------------------------------
	// Digest predictor: own copy of the chain, block and bit count.
	// ---------------------------------------------------------------------
	logic [31:0] chain [5];
	logic [31:0] blk [16];
	logic [63:0] bit_count;
	out_item_t   digest_q [$];   // expected digest words, oldest first
	in_item_t    pending_q [$];  // items waiting for the driver
	int          errors;

	function automatic logic [31:0] rol(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, t;
		int r;
		for (int i = 0; i < 16; i++) w[i] = blk[i];
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
		for (r = 0; r < 80; r++) begin
			if (r >= 16)
				w[r%16] = rol(w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16], 1);
			if (r < 20) begin
				f = (b & c) | (~b & d); k = K_G0;
			end else if (r < 40) begin
				f = b ^ c ^ d; k = K_G1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d); k = K_G2;
			end else begin
				f = b ^ c ^ d; k = K_G3;
			end
			t = rol(a, 5) + f + e + k + w[r%16];
			e = d; d = c; c = rol(b, 30); b = a; a = t;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
	endtask

	task automatic put_byte(input int pos, input logic [7:0] v);
		blk[pos/4][(3 - pos%4)*8 +: 8] = v;
	endtask

	task automatic chain_reset();
		for (int i = 0; i < 5; i++) chain[i] = H_INIT[i];
		bit_count = '0;
	endtask

	task automatic add_pending(input in_item_t it);
		pending_q.insert(pending_q.size(), it);
	endtask

	// Feed one accepted transfer into the predictor.
	task automatic hash_item(input in_item_t it);
		int pos;
		out_item_t o;
		if (it.byte_present) begin
			pos = int'(bit_count[8:3]);
			put_byte(pos, it.data_byte);
			bit_count += 64'd8;
			if (pos == 63) compress();
		end
		if (it.end_of_message) begin
			pos = int'(bit_count[8:3]);
			put_byte(pos, PAD_BYTE);
			for (int i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
			if (pos >= 56) begin
				compress();
				for (int i = 0; i < 16; i++) blk[i] = '0;
			end
			blk[14] = bit_count[63:32];
			blk[15] = bit_count[31:0];
			compress();
			for (int i = 0; i < 5; i++) begin
				o.digest_word = chain[i];
				o.digest_last = (i == 4);
				digest_q.insert(digest_q.size(), o);
			end
			chain_reset();
		end
	endtask

	// Build a message of len bytes, random content, optional idle items and empty end marker.
	task automatic queue_message(input int len, input bit rand_idles);
		in_item_t it;
		bit sep_end;
		sep_end = (len == 0) || ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++) begin
			if (rand_idles && $urandom_range(0, 9) == 0) begin
				it.data_byte = 8'($urandom); it.byte_present = 1'b0; it.end_of_message = 1'b0;
				add_pending(it);
			end
			it.data_byte = 8'($urandom);
			it.byte_present = 1'b1;
			it.end_of_message = (i == len - 1) && !sep_end;
			add_pending(it);
		end
		if (sep_end) begin
			it.data_byte = 8'($urandom); it.byte_present = 1'b0; it.end_of_message = 1'b1;
			add_pending(it);
		end
	endtask

	// ---------------------------------------------------------------------
	// Driver: bursts of random length with random gaps; can be held off.
	// ---------------------------------------------------------------------
	int  burst_left, gap_left;
	bit  drv_hold;      // set while the sender waits for all digests
	wire item_xfer   = item_valid && !item_stall;
	wire digest_xfer = digest_valid && !digest_stall;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else if (!item_valid || item_xfer) begin
			// slot is free this edge: present next item or idle
			if (gap_left > 0) begin
				gap_left   <= gap_left - 1;
				item_valid <= 1'b0;
			end else if (drv_hold || pending_q.size() == 0) begin
				item_valid <= 1'b0;
			end else begin
				item       <= pending_q.pop_front();
				item_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// predictor runs on what the block actually took
	always @(posedge clk) begin
		if (arst_n && item_xfer) hash_item(item);
	end

	// ---------------------------------------------------------------------
	// Receiver stall pattern and one long hold-off; monitor compares.
	// ---------------------------------------------------------------------
	int  stall_mode, mode_left, long_left;
	bit  long_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digest_stall <= 1'b0;
			stall_mode   <= 0;
			mode_left    <= 0;
			long_left    <= 0;
		end else begin
			if (long_req && long_left == 0) long_left <= 1000;
			if (long_left > 0) begin
				long_left    <= long_left - 1;
				digest_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode <= $urandom_range(0, 2);
					mode_left  <= $urandom_range(10, 80);
				end else begin
					mode_left <= mode_left - 1;
				end
				case (stall_mode)
					0: digest_stall <= 1'b0;
					1: digest_stall <= ($urandom_range(0, 3) == 0);
					default: digest_stall <= ($urandom_range(0, 1) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		out_item_t exp_d;
		if (arst_n && digest_xfer) begin
			if (digest_q.size() == 0) begin
				$display("%0t: unexpected digest transfer: expected none, actual %h/%b",
					$realtime, digest.digest_word, digest.digest_last);
				errors++;
			end else begin
				exp_d = digest_q.pop_front();
				if (digest.digest_word !== exp_d.digest_word) begin
					$display("%0t: digest_word mismatch: expected %h, actual %h",
						$realtime, exp_d.digest_word, digest.digest_word);
					errors++;
				end
				if (digest.digest_last !== exp_d.digest_last) begin
					$display("%0t: digest_last mismatch: expected %b, actual %b",
						$realtime, exp_d.digest_last, digest.digest_last);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles with no transfer on either side
	int idle_cycles;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if (item_xfer || digest_xfer) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= 5000) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	initial begin
		in_item_t it;
		errors    = 0;
		drv_hold  = 1'b0;
		long_req  = 1'b0;
		chain_reset();
		for (int i = 0; i < 16; i++) blk[i] = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: idle item, empty message, byte extremes, short messages.
		it = '{data_byte: 8'hFF, byte_present: 1'b0, end_of_message: 1'b0};
		add_pending(it);
		queue_message(0, 1'b0);
		it = '{data_byte: 8'h00, byte_present: 1'b1, end_of_message: 1'b1};
		add_pending(it);
		it = '{data_byte: 8'hFF, byte_present: 1'b1, end_of_message: 1'b1};
		add_pending(it);
		it = '{data_byte: 8'hAA, byte_present: 1'b1, end_of_message: 1'b0};
		add_pending(it);
		it = '{data_byte: 8'h55, byte_present: 1'b1, end_of_message: 1'b1};
		add_pending(it);
		queue_message(3, 1'b0);

		// Send everything, then wait for all digests with the sender paused.
		wait (pending_q.size() == 0);
		drv_hold = 1'b1;
		while (digest_q.size() != 0 || item_valid) @(posedge clk);
		drv_hold = 1'b0;

		// Block-boundary lengths: 56 forces the pad split, 64 fills a block.
		queue_message(56, 1'b0);
		queue_message(64, 1'b0);

		// Long receiver hold-off while the sender keeps offering short messages.
		long_req = 1'b1;
		for (int m = 0; m < 10; m++) queue_message($urandom_range(0, 4), 1'b0);
		wait (long_left > 0);
		long_req = 1'b0;

		// Random short messages with idle items.
		for (int m = 0; m < 8; m++) queue_message($urandom_range(0, 8), 1'b1);

		wait (pending_q.size() == 0);
		while (item_valid) @(posedge clk);
		while (digest_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0 && digest_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
